// ===== rtl/ube_pkg.sv =====
// Shared types, character codes and byte classification helpers for the UTF-8 aware escaper.
`default_nettype none

package ube_pkg;

	// Default depth of the queue between the classifier and the emitter.
	localparam int FIFO_DEPTH_DEF = 2;

	// Register address decode: bit 2 of paddr selects the register slot.
	localparam logic REG_HEX_UPPERCASE = 1'b0;

	// Byte ranges and masks used to classify input bytes.
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_DEL  = 8'h7F;
	localparam logic [7:0] MASK_2B    = 8'hE0;
	localparam logic [7:0] LEAD_2B    = 8'hC0;
	localparam logic [7:0] MASK_3B    = 8'hF0;
	localparam logic [7:0] LEAD_3B    = 8'hE0;
	localparam logic [7:0] MASK_4B    = 8'hF8;
	localparam logic [7:0] LEAD_4B    = 8'hF0;
	localparam logic [7:0] MASK_CONT  = 8'hC0;
	localparam logic [7:0] CONT_BITS  = 8'h80;

	// Bytes with a short backslash escape.
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_NUL = 8'h00;

	// Output characters.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_LA     = 8'h61;

	// How one decided byte leaves the block.
	typedef enum logic {
		KIND_PASS,
		KIND_ESC
	} kind_t;

	// One decided group of bytes, handed from the classifier to the emitter.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		kind_t [3:0]     kinds;
		logic [2:0]      cnt;
		logic            end_flag;
	} job_t;

	// Total length of the sequence that a lead byte opens, or zero.
	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] len;
		len = 3'd0;
		if ((c & MASK_2B) == LEAD_2B) begin
			len = 3'd2;
		end else if ((c & MASK_3B) == LEAD_3B) begin
			len = 3'd3;
		end else if ((c & MASK_4B) == LEAD_4B) begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] c);
		return (c & MASK_CONT) == CONT_BITS;
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= PRINT_LO) && (c < PRINT_DEL);
	endfunction

	// One hex digit in the selected case.
	function automatic logic [7:0] hex_digit(input logic [3:0] v, input logic upper);
		logic [7:0] ch;
		if (v < 4'd10) begin
			ch = CH_ZERO + {4'd0, v};
		end else begin
			ch = (upper ? CH_UA : CH_LA) + {4'd0, v} - 8'd10;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ube_ifs.sv =====
// Valid/ready channel interfaces for the input bytes and the output characters.
`default_nettype none

interface ube_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_input;

	modport source (output valid, output data_byte, output end_of_input, input ready);
	modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface ube_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       stream_last;

	modport source (output valid, output out_char, output run_last, output stream_last,
		input ready);
	modport sink   (input valid, input out_char, input run_last, input stream_last,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/ube_front.sv =====
// Classifier: joins held bytes with the new byte, decides them and keeps the undecided tail.
`default_nettype none

module ube_front import ube_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ube_in_if.sink    in_ch,
	output job_t      job,
	output logic      push,
	input  wire logic full
);

	logic [2:0][7:0] held_q;
	logic [1:0]      held_count_q;
	logic [3:0][7:0] win;
	logic [2:0]      n;
	logic [2:0]      ndec;
	kind_t [3:0]     kinds;
	logic            accept;
	logic [2:0][7:0] held_next;
	logic [1:0]      count_next;

	// A transaction is taken whenever the queue has room.
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Window of held bytes followed by the new byte.
	assign n = {1'b0, held_count_q} + 3'd1;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (3'(i) < {1'b0, held_count_q}) begin
				win[i] = held_q[i];
			end else if (3'(i) == {1'b0, held_count_q}) begin
				win[i] = in_ch.data_byte;
			end else begin
				win[i] = 8'd0;
			end
		end
		// The last position only ever takes the new byte, behind a full hold buffer.
		win[3] = (held_count_q == 2'd3) ? in_ch.data_byte : 8'd0;
	end

	// Decide each window position in order; stop at a sequence still waiting for bytes.
	always_comb begin
		logic [1:0] skip;
		logic       stop;
		logic       ok;
		logic [1:0] need;
		logic [2:0] avail;
		logic [6:0] cont_ext;
		skip     = 2'd0;
		stop     = 1'b0;
		ok       = 1'b1;
		need     = 2'd0;
		avail    = 3'd0;
		ndec     = n;
		cont_ext = 7'd0;
		for (int i = 0; i < 4; i++) begin
			cont_ext[i] = is_cont(win[i]);
		end
		for (int i = 0; i < 4; i++) begin
			kinds[i] = KIND_PASS;
			if ((3'(i) < n) && !stop) begin
				if (skip != 2'd0) begin
					skip = skip - 2'd1;
				end else if (is_print(win[i])) begin
					kinds[i] = KIND_PASS;
				end else if (seq_len(win[i]) != 3'd0) begin
					need  = 2'(seq_len(win[i]) - 3'd1);
					avail = n - 3'(i) - 3'd1;
					ok    = 1'b1;
					for (int j = 1; j < 4; j++) begin
						if ((2'(j) <= need) && (3'(j) <= avail) && !cont_ext[i + j]) begin
							ok = 1'b0;
						end
					end
					if (!ok) begin
						kinds[i] = KIND_ESC;
					end else if (avail >= {1'b0, need}) begin
						skip = need;
					end else if (in_ch.end_of_input) begin
						kinds[i] = KIND_ESC;
					end else begin
						stop = 1'b1;
						ndec = 3'(i);
					end
				end else begin
					kinds[i] = KIND_ESC;
				end
			end
		end
	end

	// Undecided tail moves to the front of the hold buffer.
	assign count_next = 2'(n - ndec);
	always_comb begin
		logic [2:0] idx;
		for (int k = 0; k < 3; k++) begin
			idx = ndec + 3'(k);
			if (2'(k) < count_next) begin
				held_next[k] = win[idx[1:0]];
			end else begin
				held_next[k] = 8'd0;
			end
		end
	end

	// Groups with no decided byte cause no output and are not queued.
	assign push         = accept && (ndec != 3'd0);
	assign job.bytes    = win;
	assign job.kinds    = kinds;
	assign job.cnt      = ndec;
	assign job.end_flag = in_ch.end_of_input;

	// Hold buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			held_count_q <= 2'd0;
		end else if (accept) begin
			held_q       <= held_next;
			held_count_q <= count_next;
		end
	end

	// Only an open lead byte can head the hold buffer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q != 2'd0) |-> (seq_len(held_q[0]) != 3'd0))
		else $error("hold buffer does not start with a lead byte");

	// The end of the stream leaves nothing held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.end_of_input) |=> (held_count_q == 2'd0))
		else $error("bytes still held after end of stream");

endmodule

`default_nettype wire

// ===== rtl/ube_fifo.sv =====
// Short register queue that decouples the classifier from the emitter.
`default_nettype none

module ube_fifo import ube_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wdata,
	input  wire logic pop,
	output job_t      rdata,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Neither side may overrun the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overrun");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underrun");

endmodule

`default_nettype wire

// ===== rtl/ube_back.sv =====
// Emitter: turns queued byte groups into output characters, one character per cycle while the output is ready.
`default_nettype none

module ube_back import ube_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic empty,
	output logic      pop,
	input  wire logic hex_upper,
	ube_out_if.source out_ch
);

	logic [1:0] bi_q;
	logic [1:0] ci_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       stream_last_q;

	logic [7:0] cur;
	logic       special;
	logic [1:0] lastc;
	logic [7:0] ch;
	logic       byte_done;
	logic       job_done;
	logic       advance;

	assign cur = job.bytes[bi_q];

	// Character for the current byte and position within its escape.
	always_comb begin
		special = cur inside {BYTE_LF, BYTE_TAB, BYTE_CR, BYTE_NUL};
		if (job.kinds[bi_q] == KIND_PASS) begin
			lastc = 2'd0;
			ch    = cur;
		end else begin
			lastc = special ? 2'd1 : 2'd3;
			case (ci_q)
				2'd0: ch = CH_BSLASH;
				2'd1: begin
					if (!special) begin
						ch = CH_X;
					end else begin
						case (cur)
							BYTE_LF:  ch = CH_N;
							BYTE_TAB: ch = CH_T;
							BYTE_CR:  ch = CH_R;
							default:  ch = CH_ZERO;
						endcase
					end
				end
				2'd2:    ch = hex_digit(cur[7:4], hex_upper);
				default: ch = hex_digit(cur[3:0], hex_upper);
			endcase
		end
	end

	assign byte_done = (ci_q == lastc);
	assign job_done  = byte_done && ({1'b0, bi_q} == job.cnt - 3'd1);
	assign advance   = !empty && (!out_valid_q || out_ch.ready);
	assign pop       = advance && job_done;

	// Position counters within the queued group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q <= 2'd0;
			ci_q <= 2'd0;
		end else if (advance) begin
			ci_q <= byte_done ? 2'd0 : ci_q + 2'd1;
			if (job_done) begin
				bi_q <= 2'd0;
			end else if (byte_done) begin
				bi_q <= bi_q + 2'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q    <= ch;
			run_last_q    <= job_done;
			stream_last_q <= job_done && job.end_flag;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_char    = out_char_q;
	assign out_ch.run_last    = run_last_q;
	assign out_ch.stream_last = stream_last_q;

	// Retiring a queued group always marks the character it sends as the last of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && run_last_q))
		else $error("group retired without a run-last character");

endmodule

`default_nettype wire

// ===== rtl/utf8_aware_byte_escaper.sv =====
// Top level of the UTF-8 aware byte escaper: configuration register, classifier, queue, emitter.
//
//  Channel  | Role   | Payload                              | Transfer
//  ---------+--------+--------------------------------------+-------------------------------
//  in_ch    | sink   | data_byte[7:0], end_of_input         | valid && ready
//  out_ch   | source | out_char[7:0], run_last, stream_last | valid && ready
//  APB      | slave  | hex_uppercase at byte address 0      | psel && penable && pwrite
//
// The classifier decides a byte in the cycle of its transaction or holds it while its sequence
// waits; the emitter sends one character per cycle while the output is ready (four for a hex
// escape, two for a short escape, one per passed byte) from its single output character register.
// Reset is asynchronous and active low; it empties the hold buffer and the queue.
// Input stalls only when the queue is full; output stalls hold the output register.
`default_nettype none

module utf8_aware_byte_escaper import ube_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ube_in_if.sink           in_ch,
	ube_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic hex_upper_q;
	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_upper_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEX_UPPERCASE)) begin
			hex_upper_q <= pwdata[0];
		end
	end

	// Register read back; the low address bits are ignored.
	assign prdata = (paddr[2] == REG_HEX_UPPERCASE) ? {31'd0, hex_upper_q} : 32'd0;

	ube_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.job    (push_job),
		.push   (push),
		.full   (full)
	);

	ube_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (head_job),
		.full   (full),
		.empty  (empty)
	);

	ube_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.empty     (empty),
		.pop       (pop),
		.hex_upper (hex_upper_q),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire
